FILE: src/keyed_fifo_with_promote_remove_assert.svh
// Assertion macros shared by the keyed FIFO RTL.
// Depends on nothing; included by the top level.
`ifndef KEYED_FIFO_WITH_PROMOTE_REMOVE_ASSERT_SVH
`define KEYED_FIFO_WITH_PROMOTE_REMOVE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KFPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed fifo: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KFPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed fifo: next-cycle check failed");

`endif

FILE: src/kfpr_pkg.sv
// Shared types and constants of the keyed FIFO.
// No dependencies; used by the channel interfaces and the top level.
package kfpr_pkg;

   // Store depth and derived widths.
   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int QCNT_W  = 5;

   // Request kinds.
   localparam logic [2:0] KIND_ENQUEUE = 3'd0;
   localparam logic [2:0] KIND_DEQUEUE = 3'd1;
   localparam logic [2:0] KIND_PROMOTE = 3'd2;
   localparam logic [2:0] KIND_CANCEL  = 3'd3;
   localparam logic [2:0] KIND_CLEAR   = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef logic        [2:0]  kind_type;
   typedef logic signed [31:0] key_type;
   typedef logic        [31:0] payload_type;
   typedef logic        [1:0]  status_type;
   typedef logic [QCNT_W-1:0]  qcount_type;

   // One stored entry.
   typedef struct packed {
      key_type     key;
      payload_type payload;
   } entry_type;

endpackage

FILE: src/kfpr_req_if.sv
// Request channel: valid/ready handshake with the request fields.
// Depends on kfpr_pkg.
interface kfpr_req_if;
   import kfpr_pkg::*;

   logic        valid;
   logic        ready;
   kind_type    req_type;
   key_type     order_id;
   payload_type order_payload;

   modport source (output valid, req_type, order_id, order_payload, input ready);
   modport sink   (input valid, req_type, order_id, order_payload, output ready);
endinterface

FILE: src/kfpr_rsp_if.sv
// Result channel: valid/ready handshake with the result fields.
// Depends on kfpr_pkg.
interface kfpr_rsp_if;
   import kfpr_pkg::*;

   logic        valid;
   logic        ready;
   status_type  status;
   key_type     out_id;
   payload_type out_payload;
   qcount_type  queue_count;
   logic        queue_empty;

   modport source (output valid, status, out_id, out_payload, queue_count, queue_empty,
                   input ready);
   modport sink   (input valid, status, out_id, out_payload, queue_count, queue_empty,
                   output ready);
endinterface

FILE: src/keyed_fifo_with_promote_remove.sv
// Keyed FIFO with promote-to-front and remove-by-key, top level.
// Depends on kfpr_pkg, kfpr_req_if, kfpr_rsp_if and the assertion header.
//
// Usage:
//   req carries one request per beat: enqueue, dequeue, promote, cancel or
//   clear, with a key and a payload. rsp returns exactly one result beat per
//   request: status, the dequeued entry (zero otherwise), the entry count
//   and an empty flag. Results leave in request order.
//   Entries live in a 16-entry single-write, single-read memory with a
//   registered read port. A small sequencer walks that memory one entry per
//   cycle, using one key comparator, to search and to shift entries.
//   Enqueue, clear, undefined kinds and requests on an empty queue finish
//   without a walk; dequeue and cancel walk every entry, and promote walks
//   up to its key, then shifts the entries ahead of it toward the tail.
//   req.ready is high only while the sequencer is idle, so a new request is
//   taken only once the previous result has moved into the output register.
//   A new request is taken while a finished result still waits; if the
//   receiver stalls, the next result waits in the sequencer meanwhile.
//   Synchronous reset empties the queue and drops any pending result.
`include "keyed_fifo_with_promote_remove_assert.svh"

module keyed_fifo_with_promote_remove (
   input logic       clock,
   input logic       reset,
   kfpr_req_if.sink  req,
   kfpr_rsp_if.source rsp
);
   import kfpr_pkg::*;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_FRONT = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]       state_ff, state_in;
   kind_type         kind_ff;
   key_type          key_ff;
   payload_type      pay_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   key_type          oid_ff, oid_in;
   payload_type      opay_ff, opay_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             issue_ff, issue_in;
   logic             data_vld_ff, data_vld_in;
   logic [IDX_W-1:0] data_idx_ff, data_idx_in;
   logic             found_ff, found_in;
   entry_type        held_ff, held_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   key_type          rsp_id_ff;
   payload_type      rsp_pay_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_load;

   // Entry memory.
   entry_type        mem [DEPTH];
   entry_type        rd_data_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   logic             req_beat;
   logic [CNT_W-1:0] count_dec;
   logic [IDX_W-1:0] last_idx;
   logic             key_hit;
   logic             rm_hit;

   assign req_beat  = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign count_dec = count_ff - CNT_W'(1);
   assign last_idx  = count_dec[IDX_W-1:0];
   assign key_hit   = (rd_data_ff.key == key_ff);
   // A dequeue removes the head; a cancel removes the first key match.
   assign rm_hit    = (kind_ff == KIND_DEQUEUE) ? (data_idx_ff == '0) : key_hit;

   // Result leaves the sequencer once the output register is free.
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp.ready);

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   // Sequencer next state and memory write control.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      oid_in      = oid_ff;
      opay_in     = opay_ff;
      rd_idx_in   = rd_idx_ff;
      issue_in    = issue_ff;
      data_vld_in = 1'b0;
      data_idx_in = data_idx_ff;
      found_in    = found_ff;
      held_in     = held_ff;
      wr_en       = 1'b0;
      wr_addr     = data_idx_ff;
      wr_data     = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            oid_in    = '0;
            opay_in   = '0;
            status_in = ST_FAIL;
            found_in  = 1'b0;
            rd_idx_in = '0;
            issue_in  = 1'b0;
            state_in  = S_RESP;
            unique case (kind_ff)
               KIND_ENQUEUE: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = count_ff[IDX_W-1:0];
                     wr_data   = '{key: key_ff, payload: pay_ff};
                     count_in  = count_ff + CNT_W'(1);
                     status_in = ST_DONE;
                  end
               end
               KIND_DEQUEUE, KIND_PROMOTE, KIND_CANCEL: begin
                  if (count_ff != '0) begin
                     issue_in = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               KIND_CLEAR: begin
                  count_in  = '0;
                  status_in = ST_DONE;
               end
               default: begin
                  status_in = ST_FAIL;
               end
            endcase
         end

         // Walk the entries from the head, one read per cycle.
         S_SCAN: begin
            if (issue_ff) begin
               data_vld_in = 1'b1;
               data_idx_in = rd_idx_ff;
               if (rd_idx_ff == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            if (data_vld_ff) begin
               if (kind_ff == KIND_PROMOTE) begin
                  priority if (data_idx_ff == '0 && key_hit) begin
                     // The head already holds the key.
                     state_in = S_RESP;
                  end else if (data_idx_ff != '0 && key_hit) begin
                     held_in     = rd_data_ff;
                     rd_idx_in   = data_idx_ff - IDX_W'(1);
                     issue_in    = 1'b1;
                     data_vld_in = 1'b0;
                     state_in    = S_SHIFT;
                  end else if (data_idx_ff == last_idx) begin
                     state_in = S_RESP;
                  end
                  if (state_in == S_RESP) begin
                     issue_in    = 1'b0;
                     data_vld_in = 1'b0;
                  end
               end else begin
                  // Entries after the removed one move one slot toward the head.
                  if (found_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = data_idx_ff - IDX_W'(1);
                     wr_data = rd_data_ff;
                  end else if (rm_hit) begin
                     found_in = 1'b1;
                     if (kind_ff == KIND_DEQUEUE) begin
                        oid_in  = rd_data_ff.key;
                        opay_in = rd_data_ff.payload;
                     end
                  end
                  if (data_idx_ff == last_idx) begin
                     issue_in    = 1'b0;
                     data_vld_in = 1'b0;
                     state_in    = S_RESP;
                     if (found_ff || rm_hit) begin
                        count_in  = count_dec;
                        status_in = ST_DONE;
                     end
                  end
               end
            end
         end

         // Move the entries ahead of the promoted one down by one slot.
         S_SHIFT: begin
            if (issue_ff) begin
               data_vld_in = 1'b1;
               data_idx_in = rd_idx_ff;
               if (rd_idx_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff - IDX_W'(1);
               end
            end
            if (data_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = data_idx_ff + IDX_W'(1);
               wr_data = rd_data_ff;
               if (data_idx_ff == '0) begin
                  issue_in    = 1'b0;
                  data_vld_in = 1'b0;
                  state_in    = S_FRONT;
               end
            end
         end

         // Put the promoted entry at the head.
         S_FRONT: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = held_ff;
            status_in = ST_DONE;
            state_in  = S_RESP;
         end

         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         data_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         data_vld_ff  <= data_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         kind_ff <= req.req_type;
         key_ff  <= req.order_id;
         pay_ff  <= req.order_payload;
      end
      status_ff   <= status_in;
      oid_ff      <= oid_in;
      opay_ff     <= opay_in;
      rd_idx_ff   <= rd_idx_in;
      data_idx_ff <= data_idx_in;
      held_ff     <= held_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_id_ff     <= oid_ff;
         rsp_pay_ff    <= opay_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.out_id      = rsp_id_ff;
   assign rsp.out_payload = rsp_pay_ff;
   assign rsp.queue_count = QCNT_W'(rsp_count_ff);
   assign rsp.queue_empty = (rsp_count_ff == '0);

   // Checks on the sequencer.
   `KFPR_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `KFPR_ASSERT_NOW(a_write_in_use, clock, reset, wr_en && (state_ff != S_EXEC),
      {1'b0, wr_addr} < count_ff)
   `KFPR_ASSERT_NEXT(a_beat_starts, clock, reset, req_beat, state_ff == S_EXEC)
   `KFPR_ASSERT_NOW(a_enq_done_nonempty, clock, reset,
      (state_ff == S_RESP) && (kind_ff == KIND_ENQUEUE) && (status_ff == ST_DONE),
      count_ff != '0)

endmodule

FILE: tb/keyed_fifo_result_check.sv
// Result checker for the keyed FIFO: watches both channels, keeps its own copy of the queue,
// and compares every result beat against the oldest predicted result.
// Depends on kfpr_pkg.
`timescale 1ns / 1ps

module keyed_fifo_result_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  kfpr_pkg::kind_type    req_type,
   input  kfpr_pkg::key_type     order_id,
   input  kfpr_pkg::payload_type order_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  kfpr_pkg::status_type  status,
   input  kfpr_pkg::key_type     out_id,
   input  kfpr_pkg::payload_type out_payload,
   input  kfpr_pkg::qcount_type  queue_count,
   input  logic                  queue_empty,
   output int                    error_count,
   output int                    pending_count
);
   import kfpr_pkg::*;

   // One predicted result beat.
   typedef struct {
      status_type  status;
      key_type     id;
      payload_type payload;
      qcount_type  count;
      logic        empty;
   } queue_outcome_type;

   entry_type         held_entries[$];
   queue_outcome_type awaited_results[$];
   int                mismatches = 0;

   // Position of the first held entry at or after start with this key, or -1.
   function automatic int locate_key(int start, key_type key);
      for (int i = start; i < held_entries.size(); i++) begin
         if (held_entries[i].key == key) return i;
      end
      return -1;
   endfunction

   // Apply one request to the held entries and return the result it produces.
   function automatic queue_outcome_type apply_request(kind_type kind, key_type key,
                                                       payload_type pay);
      queue_outcome_type res;
      entry_type         moved;
      int                pos;
      res.status  = ST_FAIL;
      res.id      = '0;
      res.payload = '0;
      case (kind)
         KIND_ENQUEUE: begin
            if (held_entries.size() >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               held_entries.push_back(entry_type'{key: key, payload: pay});
               res.status = ST_DONE;
            end
         end
         KIND_DEQUEUE: begin
            if (held_entries.size() > 0) begin
               moved = held_entries.pop_front();
               res.id      = moved.key;
               res.payload = moved.payload;
               res.status  = ST_DONE;
            end
         end
         KIND_PROMOTE: begin
            // The head itself never counts as a match for promote.
            if (held_entries.size() > 0 && held_entries[0].key != key) begin
               pos = locate_key(1, key);
               if (pos > 0) begin
                  moved = held_entries[pos];
                  held_entries.delete(pos);
                  held_entries.push_front(moved);
                  res.status = ST_DONE;
               end
            end
         end
         KIND_CANCEL: begin
            pos = locate_key(0, key);
            if (pos >= 0) begin
               held_entries.delete(pos);
               res.status = ST_DONE;
            end
         end
         KIND_CLEAR: begin
            held_entries.delete();
            res.status = ST_DONE;
         end
         default: ;
      endcase
      res.count = qcount_type'(held_entries.size());
      res.empty = (held_entries.size() == 0);
      return res;
   endfunction

   function automatic void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
   endfunction

   // Result beats are checked before the request beat of the same edge is predicted;
   // a request cannot finish in the cycle it is taken.
   always @(posedge clock) begin
      queue_outcome_type want;
      if (reset) begin
         held_entries.delete();
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result beat with no request waiting: status %0d", status);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(status));
               if (out_id !== want.id)
                  report_mismatch("out_id", want.id, out_id);
               if (out_payload !== want.payload)
                  report_mismatch("out_payload", want.payload, out_payload);
               if (queue_count !== want.count)
                  report_mismatch("queue_count", 32'(want.count), 32'(queue_count));
               if (queue_empty !== want.empty)
                  report_mismatch("queue_empty", 32'(want.empty), 32'(queue_empty));
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(apply_request(req_type, order_id, order_payload));
      end
      error_count   <= mismatches;
      pending_count <= awaited_results.size();
   end

endmodule

FILE: tb/testbench.sv
// Top of the keyed FIFO testbench: clock, reset, request stimulus, result back-pressure,
// watchdog and verdict. Depends on kfpr_pkg, both channel interfaces, the block itself
// and keyed_fifo_result_check.
`timescale 1ns / 1ps

module testbench;
   import kfpr_pkg::*;

   localparam int RANDOM_ITEMS = 1830;
   localparam int CALM_ITEMS   = 200;   // trailing items sent with no idling
   localparam int STALL_LIMIT  = 2000;  // cycles with no beat before giving up
   localparam int DRAIN_CYCLES = 60;    // beyond the longest promote latency
   localparam int KIND_MAX     = 7;     // largest value the 3-bit kind field holds

   localparam key_type KEY_MIN = key_type'(32'h8000_0000);
   localparam key_type KEY_MAX = key_type'(32'h7fff_ffff);

   logic clock;
   logic reset;
   bit   calm;
   int   error_count;
   int   pending_count;
   int   quiet_cycles;

   kfpr_req_if req_ch ();
   kfpr_rsp_if rsp_ch ();

   keyed_fifo_with_promote_remove dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   keyed_fifo_result_check result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_type      (req_ch.req_type),
      .order_id      (req_ch.order_id),
      .order_payload (req_ch.order_payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .status        (rsp_ch.status),
      .out_id        (rsp_ch.out_id),
      .out_payload   (rsp_ch.out_payload),
      .queue_count   (rsp_ch.queue_count),
      .queue_empty   (rsp_ch.queue_empty),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one request beat and hold it until it is taken; valid stays high afterward.
   task automatic send_request(kind_type kind, key_type key, payload_type pay);
      @(negedge clock);
      req_ch.valid         = 1'b1;
      req_ch.req_type      = kind;
      req_ch.order_id      = key;
      req_ch.order_payload = pay;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
   endtask

   // Stop offering requests until every predicted result has come back.
   task automatic wait_for_drain();
      idle_sender(1);
      while (pending_count != 0) @(negedge clock);
   endtask

   // Keys mostly come from a small pool so that promote and cancel find matches.
   function automatic key_type pick_key();
      case ($urandom_range(0, 11))
         0:       return KEY_MIN;
         1:       return KEY_MAX;
         2:       return '0;
         3:       return '1;
         4:       return key_type'($urandom);
         default: return key_type'($urandom_range(1, 6));
      endcase
   endfunction

   // Request mix by phase: filling toward full, draining toward empty, or balanced.
   function automatic kind_type pick_kind(int phase);
      int roll;
      int enq_pct;
      int deq_pct;
      roll = $urandom_range(0, 99);
      case (phase)
         0:       begin enq_pct = 65; deq_pct = 8;  end
         1:       begin enq_pct = 25; deq_pct = 35; end
         default: begin enq_pct = 40; deq_pct = 20; end
      endcase
      if (roll < enq_pct) return KIND_ENQUEUE;
      roll -= enq_pct;
      if (roll < deq_pct) return KIND_DEQUEUE;
      roll -= deq_pct;
      if (roll < 2) return KIND_CLEAR;
      if (roll < 4) return kind_type'($urandom_range(KIND_CLEAR + 1, KIND_MAX));
      return (roll % 2) ? KIND_PROMOTE : KIND_CANCEL;
   endfunction

   // Result side: random stall bursts, none once the run has gone calm.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
         rsp_ch.ready = (stall_left == 0);
         if (stall_left > 0) stall_left--;
         @(negedge clock);
      end
   end

   // Watchdog: counts cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("keyed_fifo_with_promote_remove test failed");
            $finish;
         end
      end
   end

   // Request stimulus and verdict.
   initial begin
      calm                 = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.req_type      = KIND_ENQUEUE;
      req_ch.order_id      = '0;
      req_ch.order_payload = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: requests on an empty queue, undefined kinds, key extremes,
      // promote of the head, found and missing keys, and clears.
      send_request(KIND_DEQUEUE, '0, '0);
      send_request(KIND_PROMOTE, KEY_MAX, '0);
      send_request(KIND_CANCEL, KEY_MIN, '0);
      for (int k = KIND_CLEAR + 1; k <= KIND_MAX; k++)
         send_request(kind_type'(k), '1, '1);
      send_request(KIND_ENQUEUE, KEY_MIN, '0);
      send_request(KIND_ENQUEUE, KEY_MAX, '1);
      send_request(KIND_ENQUEUE, '0, 32'ha5a5_a5a5);
      send_request(KIND_ENQUEUE, '1, 32'h5a5a_5a5a);
      send_request(KIND_PROMOTE, KEY_MIN, '0);
      send_request(KIND_PROMOTE, '1, '0);
      send_request(KIND_PROMOTE, 32'sd12345, '0);
      send_request(KIND_CANCEL, '0, '0);
      send_request(KIND_CANCEL, '1, '0);
      send_request(KIND_CANCEL, 32'sd999, '0);
      send_request(KIND_ENQUEUE, KEY_MAX, 32'h0000_0001);
      send_request(KIND_PROMOTE, KEY_MAX, '0);
      send_request(KIND_DEQUEUE, '0, '0);
      send_request(KIND_CLEAR, '0, '0);
      send_request(KIND_CLEAR, '0, '0);
      send_request(KIND_DEQUEUE, '0, '0);
      wait_for_drain();

      // Random: phases of 60 items alternate between filling, draining and balance.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         send_request(pick_kind((n / 60) % 3), pick_key(), payload_type'($urandom));
         if (!calm && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 7));
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("keyed_fifo_with_promote_remove test passed");
      end else begin
         $display("keyed_fifo_with_promote_remove test failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/kfpr_pkg.sv
src/kfpr_req_if.sv
src/kfpr_rsp_if.sv
src/keyed_fifo_with_promote_remove.sv
tb/keyed_fifo_result_check.sv
tb/testbench.sv
